### hw/rtl/turtle_plotter_bitmap_macros.svh
// Assertion macros shared by the checker of the turtle plotter.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef TURTLE_PLOTTER_BITMAP_MACROS_SVH
`define TURTLE_PLOTTER_BITMAP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TPB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/tpb_pkg.sv
// Package for the turtle plotter: grid sizing, command and heading codes,
// and the control and status bundles between controller and datapath. No dependencies.
package tpb_pkg;

    // Grid size; the bitmap and the result fields hold at most 32 cells a side.
    localparam int GRID_SIZE = 32;
    localparam int GRID_EFF  = (GRID_SIZE > 32) ? 32 : GRID_SIZE;
    localparam int ADDR_W    = (GRID_EFF > 1) ? $clog2(GRID_EFF) : 1;
    localparam int DCNT_W    = $clog2(GRID_EFF + 1);

    // Field widths of the transactions.
    localparam int CMD_W  = 3;
    localparam int STEP_W = 8;
    localparam int POS_W  = 5;
    localparam int ROW_W  = 32;

    localparam logic [POS_W:0]    GRID_LIM = (POS_W + 1)'(GRID_EFF);
    localparam logic [DCNT_W-1:0] DCNT_LIM = DCNT_W'(GRID_EFF);
    localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(GRID_EFF - 1);

    typedef logic [CMD_W-1:0] t_cmd;
    typedef logic [1:0]       t_heading;

    // Command codes.
    localparam t_cmd CMD_PEN_UP     = 3'd0;
    localparam t_cmd CMD_PEN_DOWN   = 3'd1;
    localparam t_cmd CMD_TURN_RIGHT = 3'd2;
    localparam t_cmd CMD_TURN_LEFT  = 3'd3;
    localparam t_cmd CMD_MOVE       = 3'd4;
    localparam t_cmd CMD_DUMP       = 3'd5;

    // Heading codes; turn left adds one, turn right subtracts one.
    localparam t_heading HEAD_POS_COL = 2'd0;
    localparam t_heading HEAD_NEG_ROW = 2'd1;
    localparam t_heading HEAD_NEG_COL = 2'd2;
    localparam t_heading HEAD_POS_ROW = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // latch a new command and apply pen and turn codes
        logic step;        // advance one cell along the heading
        logic mark;        // write the marked cell back to the bitmap
        logic block;       // record that the move hit the grid edge
        logic dump_start;  // reset the row counters of a dump
        logic dump_run;    // stream bitmap rows to the output
        logic emit;        // load the single result of a command
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic steps_zero;  // no cells left to advance
        logic at_edge;     // the next cell lies outside the grid
        logic pen;         // pen is down
        logic out_free;    // the output register can take a result
        logic dump_done;   // every row of the dump has been handed over
    } t_ctl_stat;

endpackage

### hw/rtl/tpb_if.sv
// Valid/ready channel interfaces for the command and result transactions.
// Depends on tpb_pkg for the field widths.
interface tpb_in_if import tpb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [STEP_W-1:0] step_count;

    modport source (output valid, output cmd, output step_count, input ready);
    modport sink   (input valid, input cmd, input step_count, output ready);
endinterface

interface tpb_out_if import tpb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             status;
    logic [ROW_W-1:0] row_bits;
    logic [POS_W-1:0] row_number;
    logic [POS_W-1:0] cur_row;
    logic [POS_W-1:0] cur_col;
    logic             pen_down;
    logic             last;

    modport source (output valid, output status, output row_bits, output row_number,
                    output cur_row, output cur_col, output pen_down, output last,
                    input ready);
    modport sink   (input valid, input status, input row_bits, input row_number,
                    input cur_row, input cur_col, input pen_down, input last,
                    output ready);
endinterface

### hw/rtl/tpb_ram.sv
// Generic RAM with one write port and one read port with registered read data.
// No dependencies.
module tpb_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/tpb_ctrl.sv
// Controller state machine of the turtle plotter: sequences commands, moves and dumps.
// Depends on tpb_pkg for the command codes and the control bundles.
module tpb_ctrl import tpb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_cmd       i_in_cmd,
    output logic       o_in_ready,
    input  t_ctl_stat  i_stat,
    output t_ctl_cmd   o_ctl
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOVE = 3'd1;
    localparam logic [2:0] S_MARK = 3'd2;
    localparam logic [2:0] S_RESP = 3'd3;
    localparam logic [2:0] S_DUMP = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       in_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;

    // Next state and the commands to the datapath.
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    o_ctl.load = 1'b1;
                    case (i_in_cmd)
                        CMD_MOVE: begin
                            n_state = S_MOVE;
                        end
                        CMD_DUMP: begin
                            o_ctl.dump_start = 1'b1;
                            n_state          = S_DUMP;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_MOVE: begin
                if (i_stat.steps_zero) begin
                    n_state = S_RESP;
                end else if (i_stat.at_edge) begin
                    o_ctl.block = 1'b1;
                    n_state     = S_RESP;
                end else begin
                    o_ctl.step = 1'b1;
                    if (i_stat.pen) begin
                        n_state = S_MARK;
                    end
                end
            end
            S_MARK: begin
                o_ctl.mark = 1'b1;
                n_state    = S_MOVE;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_ctl.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_DUMP: begin
                o_ctl.dump_run = 1'b1;
                if (i_stat.dump_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hw/rtl/tpb_datapath.sv
// Datapath of the turtle plotter: pen, heading, position, bitmap RAM and output register.
// Depends on tpb_pkg, tpb_out_if and tpb_ram.
module tpb_datapath import tpb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [STEP_W-1:0] i_step_count,
    input  t_ctl_cmd          i_ctl,
    output t_ctl_stat         o_stat,
    tpb_out_if.source         o_out
);

    // Turtle state.
    logic              r_pen;
    t_heading          r_heading;
    logic [POS_W-1:0]  r_row;
    logic [POS_W-1:0]  r_col;
    logic [STEP_W-1:0] r_steps;
    logic              r_blocked;

    // Bitmap row valid bits; a row never written reads as all zero.
    logic [GRID_EFF-1:0] r_row_valid;

    // Dump pipeline.
    logic [DCNT_W-1:0] r_dump_cnt;
    logic              r_pend;
    logic [ADDR_W-1:0] r_pend_row;
    logic              r_rd_valid;

    // Output register.
    logic             r_out_valid;
    logic             r_out_status;
    logic [ROW_W-1:0] r_out_row_bits;
    logic [POS_W-1:0] r_out_row_number;
    logic [POS_W-1:0] r_out_cur_row;
    logic [POS_W-1:0] r_out_cur_col;
    logic             r_out_pen;
    logic             r_out_last;

    logic [POS_W-1:0]    n_row;
    logic [POS_W-1:0]    n_col;
    logic                at_edge;
    logic                out_free;
    logic                dump_consume;
    logic                dump_issue;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [GRID_EFF-1:0] ram_rdata;
    logic [GRID_EFF-1:0] ram_wdata;
    logic [GRID_EFF-1:0] row_data;
    logic [GRID_EFF-1:0] col_bit;
    logic [ROW_W-1:0]    row_ext;

    // Next cell along the heading and whether it leaves the grid.
    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        at_edge = 1'b0;
        case (r_heading)
            HEAD_POS_COL: begin
                at_edge = (({1'b0, r_col} + (POS_W + 1)'(1)) >= GRID_LIM);
                n_col   = r_col + POS_W'(1);
            end
            HEAD_NEG_ROW: begin
                at_edge = (r_row == '0);
                n_row   = r_row - POS_W'(1);
            end
            HEAD_NEG_COL: begin
                at_edge = (r_col == '0);
                n_col   = r_col - POS_W'(1);
            end
            default: begin
                at_edge = (({1'b0, r_row} + (POS_W + 1)'(1)) >= GRID_LIM);
                n_row   = r_row + POS_W'(1);
            end
        endcase
    end

    // Dump reads one row ahead of the output register and holds it on a stall.
    assign out_free     = !r_out_valid || o_out.ready;
    assign dump_consume = i_ctl.dump_run && r_pend && out_free;
    assign dump_issue   = i_ctl.dump_run && (r_dump_cnt != DCNT_LIM)
                          && (!r_pend || dump_consume);

    // RAM read for the dump or for the cell just stepped onto.
    assign ram_re    = dump_issue || (i_ctl.step && r_pen);
    assign ram_raddr = dump_issue ? r_dump_cnt[ADDR_W-1:0] : n_row[ADDR_W-1:0];
    assign row_data  = r_rd_valid ? ram_rdata : '0;

    // Read-modify-write of the marked cell.
    always_comb begin
        col_bit                     = '0;
        col_bit[r_col[ADDR_W-1:0]]  = 1'b1;
        ram_wdata                   = row_data | col_bit;
        row_ext                     = '0;
        row_ext[GRID_EFF-1:0]       = row_data;
    end

    tpb_ram #(
        .WIDTH (GRID_EFF),
        .DEPTH (GRID_EFF)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (i_ctl.mark),
        .i_waddr (r_row[ADDR_W-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen       <= 1'b0;
            r_heading   <= HEAD_POS_COL;
            r_row       <= '0;
            r_col       <= '0;
            r_blocked   <= 1'b0;
            r_row_valid <= '0;
            r_dump_cnt  <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_blocked <= 1'b0;
                case (i_cmd)
                    CMD_PEN_UP:     r_pen     <= 1'b0;
                    CMD_PEN_DOWN:   r_pen     <= 1'b1;
                    CMD_TURN_RIGHT: r_heading <= r_heading + 2'd3;
                    CMD_TURN_LEFT:  r_heading <= r_heading + 2'd1;
                    default: begin
                    end
                endcase
            end
            if (i_ctl.block) begin
                r_blocked <= 1'b1;
            end
            if (i_ctl.step) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (i_ctl.mark) begin
                r_row_valid[r_row[ADDR_W-1:0]] <= 1'b1;
            end
            if (i_ctl.dump_start) begin
                r_dump_cnt <= '0;
                r_pend     <= 1'b0;
            end else begin
                if (dump_issue) begin
                    r_dump_cnt <= r_dump_cnt + DCNT_W'(1);
                    r_pend     <= 1'b1;
                end else if (dump_consume) begin
                    r_pend <= 1'b0;
                end
            end
            if (i_ctl.emit || dump_consume) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_steps <= i_step_count;
        end else if (i_ctl.step) begin
            r_steps <= r_steps - STEP_W'(1);
        end
        if (ram_re) begin
            r_rd_valid <= r_row_valid[ram_raddr];
        end
        if (dump_issue) begin
            r_pend_row <= r_dump_cnt[ADDR_W-1:0];
        end
        if (i_ctl.emit) begin
            r_out_status     <= r_blocked;
            r_out_row_bits   <= '0;
            r_out_row_number <= '0;
            r_out_last       <= 1'b1;
        end else if (dump_consume) begin
            r_out_status     <= 1'b0;
            r_out_row_bits   <= row_ext;
            r_out_row_number <= POS_W'(r_pend_row);
            r_out_last       <= (r_pend_row == LAST_ROW);
        end
        if (i_ctl.emit || dump_consume) begin
            r_out_cur_row <= r_row;
            r_out_cur_col <= r_col;
            r_out_pen     <= r_pen;
        end
    end

    // Status to the controller.
    assign o_stat.steps_zero = (r_steps == '0);
    assign o_stat.at_edge    = at_edge;
    assign o_stat.pen        = r_pen;
    assign o_stat.out_free   = out_free;
    assign o_stat.dump_done  = (r_dump_cnt == DCNT_LIM) && !r_pend;

    // Result channel; position and pen are captured with the result, since the
    // next command may start while a result still waits.
    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.row_bits   = r_out_row_bits;
    assign o_out.row_number = r_out_row_number;
    assign o_out.cur_row    = r_out_cur_row;
    assign o_out.cur_col    = r_out_cur_col;
    assign o_out.pen_down   = r_out_pen;
    assign o_out.last       = r_out_last;

endmodule

### hw/rtl/turtle_plotter_bitmap.sv
// Turtle plotter over a GRID_SIZE square bitmap (capped at 32), cleared at reset.
// Each command transaction gives one result transaction, or one per row for a dump.
// Pen, turn and unused commands pass from idle to the response state, which loads
// the result once the output register is free. A move advances one cell per step
// along the heading; with the pen down each step is followed by a mark state, since
// each marked cell is a read-modify-write of its bitmap row through the RAM's
// registered read port; a blocked move stops at the edge with the cells it took.
// A dump streams one row per cycle while the result channel is ready. No clearing
// pass is needed after reset: per-row valid bits make unwritten rows read as zero.
// A new command is accepted once the previous one has loaded its last result into
// the output register.
module turtle_plotter_bitmap import tpb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tpb_in_if.sink    i_in,
    tpb_out_if.source o_out
);

    t_ctl_cmd  ctl;
    t_ctl_stat stat;
    logic      in_ready;

    assign i_in.ready = in_ready;

    // Command sequencing.
    tpb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    // Turtle state, bitmap and result register.
    tpb_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_in.cmd),
        .i_step_count (i_in.step_count),
        .i_ctl        (ctl),
        .o_stat       (stat),
        .o_out        (o_out)
    );

endmodule

### hw/rtl/tpb_chk.sv
// Port-level checker for the turtle plotter, bound to the top level.
// Depends on tpb_pkg and turtle_plotter_bitmap_macros.svh.
`include "turtle_plotter_bitmap_macros.svh"

module tpb_chk import tpb_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_out_status,
    input logic [ROW_W-1:0] i_out_row_bits,
    input logic [POS_W-1:0] i_out_row_number,
    input logic             i_out_last
);

    // A stalled result transaction keeps its payload.
    `TPB_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_row_bits) && $stable(i_out_row_number) && $stable(i_out_last), "stalled result changed")

    // A blocked move reports one single result with no row data.
    `TPB_ASSERT_SAME(a_blocked_single, i_out_valid && i_out_status, i_out_last && (i_out_row_bits == '0) && (i_out_row_number == '0), "blocked result carries row data")

    // After a command is accepted, the next one waits for its results.
    `TPB_ASSERT_NEXT(a_one_at_a_time, i_in_valid && i_in_ready, !i_in_ready, "command accepted back to back")

    // While dump rows remain, no new command is taken.
    `TPB_ASSERT_NEXT(a_dump_busy, i_out_valid && i_out_ready && !i_out_last, !i_in_ready, "command accepted in the middle of a dump")

endmodule

bind turtle_plotter_bitmap tpb_chk u_tpb_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_status     (o_out.status),
    .i_out_row_bits   (o_out.row_bits),
    .i_out_row_number (o_out.row_number),
    .i_out_last       (o_out.last)
);
